### hw/rtl/sctr_pkg.sv
// Shared types and constants for the cache hit/miss tracker.
`timescale 1ns / 1ps
package sctr_pkg;

  // LINES must be a power of two: line and set indexes are low address bits.
  localparam int LINES = 4;
  localparam int SETS = LINES / 2;
  localparam int ADDR_BITS = 32;
  localparam int IN_ADDR_W = 32;
  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int LINE_USED_W = 2;
  localparam int ORG_W = 2;
  localparam int OUT_DATA_W = 8;

  localparam logic [ORG_W-1:0] ORG_DIRECT = 2'd0;
  localparam logic [ORG_W-1:0] ORG_TWO_WAY = 2'd1;
  localparam logic [ORG_W-1:0] ORG_FULL = 2'd2;

  // Lookup result rippling along the row of line cells; lowest index wins.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } chain_t;

endpackage

### hw/rtl/sctr_cell.sv
// One cache line cell: stored address, valid mark, compare and chain stage.
`timescale 1ns / 1ps
module sctr_cell
  import sctr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     cell_idx,
  input  logic                 search_en,
  input  logic [ADDR_BITS-1:0] query,
  input  logic                 fill_en,
  input  chain_t               chain_in,
  output chain_t               chain_out
);

  logic                 valid;
  logic [ADDR_BITS-1:0] line_addr;
  logic                 match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fill_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_en) begin
      line_addr <= query;
    end
  end

  assign match = search_en && valid && (line_addr == query);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && match) begin
      chain_out.hit = 1'b1;
      chain_out.idx = cell_idx;
    end
  end

endmodule

### hw/rtl/small_cache_hit_miss_tracker.sv
// Top level: stream ports, lookup sequencing, replacement state, result register.
`timescale 1ns / 1ps
// Cache hit/miss tracker over a row of line cells. Each accepted address is
// looked up in the cycle after its transfer: every cell compares its stored
// address in parallel and the first hit ripples down the row. A miss fills the
// chosen line in that same cycle and the result goes to an output register.
// No new address is taken while a lookup is in progress; the next address is
// taken in the cycle the result is presented if the result is taken at once,
// the pace being set by the lookup-then-update step on the line cells. The user
// must write the organization register (0 direct mapped, 1 two-way LRU, 2 or 3
// fully associative FIFO) only while the block is idle; it does not enforce it.
module small_cache_hit_miss_tracker
  import sctr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_ADDR_W-1:0]  s_axis_tdata,   // [31:0] address
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] hit, [2:1] line_used, rest 0
  input  logic                  cfg_wr_en,
  input  logic [ORG_W-1:0]      cfg_wr_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                   state;
  logic                   state_next;
  logic [ORG_W-1:0]       organization;
  logic [ADDR_BITS-1:0]   query;
  logic [SETS-1:0]        victim;
  logic [IDX_W-1:0]       fill_pointer;
  logic                   out_valid;
  logic                   out_hit;
  logic [LINE_USED_W-1:0] out_line;

  chain_t                 chain [LINES+1];
  logic [LINES-1:0]       search_en;
  logic [LINES-1:0]       fill_en;
  logic [IDX_W-1:0]       direct_idx;
  logic [SET_W-1:0]       set_idx;
  logic                   is_direct;
  logic                   is_two_way;
  logic                   look_hit;
  logic [IDX_W-1:0]       look_line;
  logic [IDX_W-1:0]       fill_line;
  logic                   accept;

  assign direct_idx = query[IDX_W-1:0];
  assign set_idx    = (SETS > 1) ? query[SET_W-1:0] : '0;
  assign is_direct  = (organization == ORG_DIRECT);
  assign is_two_way = (organization == ORG_TWO_WAY);

  assign chain[0] = '{hit: 1'b0, idx: '0};

  for (genvar i = 0; i < LINES; i++) begin : g_cell
    always_comb begin
      if (is_direct) begin
        search_en[i] = (direct_idx == IDX_W'(i));
      end else if (is_two_way) begin
        search_en[i] = (i < 2 * SETS) && (set_idx == SET_W'(i / 2));
      end else begin
        search_en[i] = 1'b1;
      end
    end

    assign fill_en[i] = (state == ST_LOOK) && !look_hit && (fill_line == IDX_W'(i));

    sctr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(i)),
      .search_en (search_en[i]),
      .query     (query),
      .fill_en   (fill_en[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  assign look_hit = chain[LINES].hit;

  always_comb begin
    if (is_direct) begin
      fill_line = direct_idx;
    end else if (is_two_way) begin
      fill_line = IDX_W'({set_idx, victim[set_idx]});
    end else begin
      fill_line = fill_pointer;
    end
  end

  assign look_line = look_hit ? chain[LINES].idx : fill_line;

  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOOK;
      end
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      organization <= ORG_DIRECT;
      victim       <= '0;
      fill_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        organization <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_LOOK) begin
        out_valid <= 1'b1;
        // victim becomes the way not used, on hit and on miss alike
        if (is_two_way) begin
          victim[set_idx] <= ~look_line[0];
        end
        if (!is_direct && !is_two_way && !look_hit) begin
          fill_pointer <= (fill_pointer == IDX_W'(LINES - 1)) ? '0 : fill_pointer + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query <= s_axis_tdata[ADDR_BITS-1:0];
    end
    if (state == ST_LOOK) begin
      out_hit  <= look_hit;
      out_line <= LINE_USED_W'(look_line);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_line, out_hit});

endmodule

### tb/sctr_scoreboard_pkg.sv
// Scoreboard class for the cache hit/miss tracker testbench: line-store predictor and result check.
`timescale 1ns / 1ps
package sctr_scoreboard_pkg;
  import sctr_pkg::*;

  typedef struct {
    logic [IN_ADDR_W-1:0]   address;
    logic                   hit;
    logic [LINE_USED_W-1:0] line;
  } lookup_t;

  class cache_scoreboard;
    logic [ORG_W-1:0]     organization;
    bit                   line_valid [LINES];
    logic [ADDR_BITS-1:0] line_addr [LINES];
    bit                   victim_way [SETS];
    int                   fill_ptr;
    lookup_t              expected_lookups [$];
    int                   errors;

    function new();
      organization = ORG_DIRECT;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      foreach (line_addr[i]) line_addr[i] = '0;
      foreach (victim_way[i]) victim_way[i] = 1'b0;
      fill_ptr = 0;
      errors = 0;
    endfunction

    function void set_organization(logic [ORG_W-1:0] org);
      organization = org;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    function bit line_holds(int idx, logic [ADDR_BITS-1:0] a);
      return line_valid[idx] && (line_addr[idx] == a);
    endfunction

    function void fill_line(int idx, logic [ADDR_BITS-1:0] a);
      line_addr[idx] = a;
      line_valid[idx] = 1'b1;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Predict the lookup for one accepted address and update the line store.
    function void note_access(logic [IN_ADDR_W-1:0] access);
      lookup_t              r;
      logic [ADDR_BITS-1:0] a;
      int                   set_idx;
      int                   base;
      int                   way;
      int                   line;
      a = access[ADDR_BITS-1:0];
      r.address = access;
      r.hit = 1'b0;
      line = 0;
      case (organization)
        ORG_DIRECT: begin
          line = int'(a % LINES);
          if (line_holds(line, a)) r.hit = 1'b1;
          else fill_line(line, a);
        end
        ORG_TWO_WAY: begin
          set_idx = int'(a % SETS);
          base = set_idx * 2;
          if (line_holds(base, a)) begin
            r.hit = 1'b1;
            way = 0;
          end else if (line_holds(base + 1, a)) begin
            r.hit = 1'b1;
            way = 1;
          end else begin
            way = victim_way[set_idx];
            fill_line(base + way, a);
          end
          line = base + way;
          // next victim is always the way not touched now
          victim_way[set_idx] = (way == 0);
        end
        default: begin
          // fully associative; the spare code maps here too
          for (int i = 0; i < LINES; i++) begin
            if (line_holds(i, a)) begin
              r.hit = 1'b1;
              line = i;
              break;
            end
          end
          if (!r.hit) begin
            line = fill_ptr % LINES;
            fill_line(line, a);
            fill_ptr = (line + 1) % LINES;
          end
        end
      endcase
      r.line = LINE_USED_W'(line);
      expected_lookups.push_back(r);
    endfunction

    function void check_lookup(logic [OUT_DATA_W-1:0] data);
      lookup_t                e;
      logic                   got_hit;
      logic [LINE_USED_W-1:0] got_line;
      got_hit = data[0];
      got_line = data[LINE_USED_W:1];
      if (expected_lookups.size() == 0) begin
        flag($sformatf("result hit=%0d line=%0d with no access outstanding",
                       got_hit, got_line));
      end else begin
        e = expected_lookups.pop_front();
        if (got_hit !== e.hit || got_line !== e.line)
          flag($sformatf("address %h: expected hit=%0d line=%0d, got hit=%0d line=%0d",
                         e.address, e.hit, e.line, got_hit, got_line));
      end
    endfunction
  endclass

endpackage

### tb/tb.sv
// Testbench top for the cache hit/miss tracker: clock, reset, stream drivers, phases, watchdog.
`timescale 1ns / 1ps
module tb;
  import sctr_pkg::*;
  import sctr_scoreboard_pkg::*;

  localparam logic [ORG_W-1:0] ORG_SPARE = 2'd3;  // unused code, acts as fully associative
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 236;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_ADDR_W-1:0]  s_axis_tdata;   // [31:0] address
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] hit, [2:1] line_used, rest 0
  logic                  cfg_wr_en;
  logic [ORG_W-1:0]      cfg_wr_data;

  cache_scoreboard sb;
  int              idle_pct;
  int              quiet_cycles;

  small_cache_hit_miss_tracker DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_lookup(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(input logic [IN_ADDR_W-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_access(a);
  endtask

  // Hold the input side until every outstanding lookup has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_organization(input logic [ORG_W-1:0] org);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= org;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_organization(org);
  endtask

  initial begin
    logic [IN_ADDR_W-1:0] pool [8];
    logic [IN_ADDR_W-1:0] a;
    logic [ORG_W-1:0]     phase_org [PHASES];
    int                   pool_size;
    int                   roll;

    phase_org = '{ORG_TWO_WAY, ORG_FULL, ORG_DIRECT, ORG_SPARE,
                  ORG_TWO_WAY, ORG_DIRECT, ORG_FULL, ORG_TWO_WAY};
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = ORG_DIRECT;
    quiet_cycles = 0;
    idle_pct = 35;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Direct mapped: extremes, repeat hit, eviction by a same-index address.
    set_organization(ORG_DIRECT);
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0004);
    send_access(32'h0000_0000);
    send_access(32'h8000_0001);
    send_access(32'h7FFF_FFFE);
    // Two-way over the old contents: hits, LRU victim flips on hits and fills.
    set_organization(ORG_TWO_WAY);
    send_access(32'h0000_0000);
    send_access(32'h0000_0002);
    send_access(32'h0000_0000);
    send_access(32'h0000_0006);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0003);
    // Fully associative: FIFO fill, hit leaves state alone.
    set_organization(ORG_FULL);
    send_access(32'h0000_0006);
    send_access(32'hA5A5_A5A5);
    send_access(32'h5A5A_5A5A);
    send_access(32'h1234_5678);
    send_access(32'h5A5A_5A5A);
    // Direct fill duplicates an address, then the lowest matching line must win.
    set_organization(ORG_DIRECT);
    send_access(32'h5A5A_5A5A);
    set_organization(ORG_SPARE);
    send_access(32'h5A5A_5A5A);
    send_access(32'hDEAD_BEEF);
    send_access(32'h0000_0001);

    for (int p = 0; p < PHASES; p++) begin
      set_organization(phase_org[p]);
      idle_pct = (p == 2) ? 0 : 35;
      pool_size = $urandom_range(8, 3);
      for (int k = 0; k < pool_size; k++) pool[k] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        roll = $urandom_range(99);
        if (roll < 75) a = pool[$urandom_range(pool_size - 1)];
        else if (roll < 85) a = pool[$urandom_range(pool_size - 1)] ^ (32'h1 << $urandom_range(31));
        else if (roll < 97) a = $urandom();
        else a = $urandom_range(1) ? '1 : '0;
        send_access(a);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
